### design/ldge_pkg.sv
// Shared types and constants for the lowest-degree group extract block.
`timescale 1ns / 1ps
`default_nettype none

package ldge_pkg;

    localparam int TAG_W = 16;
    localparam int DEG_W = 16;
    localparam int CNT_W = 7;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_EXTRACTED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SINGLE,
        S_SCAN,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_init;
        logic scan_run;
        logic emit_init;
        logic emit_run;
        logic single_run;
        logic commit;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic scan_done;
        logic emit_done;
    } sts_t;

endpackage

`default_nettype wire

### design/ldge_in_if.sv
// Request channel interface: one insert or extract transaction.
`timescale 1ns / 1ps
`default_nettype none

interface ldge_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] entry_tag;
    logic [15:0] entry_degree;

    modport source (output valid, output opcode, output entry_tag, output entry_degree,
                    input ready);
    modport sink   (input valid, input opcode, input entry_tag, input entry_degree,
                    output ready);
endinterface

`default_nettype wire

### design/ldge_out_if.sv
// Result channel interface: one result transaction.
`timescale 1ns / 1ps
`default_nettype none

interface ldge_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_tag;
    logic [15:0] out_degree;
    logic [6:0]  group_count;
    logic [6:0]  remaining;
    logic        last;

    modport source (output valid, output status, output out_tag, output out_degree,
                    output group_count, output remaining, output last, input ready);
    modport sink   (input valid, input status, input out_tag, input out_degree,
                    input group_count, input remaining, input last, output ready);
endinterface

`default_nettype wire

### design/ldge_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ldge_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/ldge_ctrl.sv
// Controller state machine that sequences insert, scan and emit phases.
`timescale 1ns / 1ps
`default_nettype none

module ldge_ctrl
    import ldge_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire logic req_opcode,
    output logic      req_ready,
    output cmd_t      cmd,
    input  wire sts_t sts
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = req_valid && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_opcode == OP_INSERT || sts.count_zero)
                    begin
                        state_next = S_SINGLE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SINGLE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.emit_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.capture   = accept;
                cmd.scan_init = accept;
            end
            S_SINGLE:
            begin
                cmd.single_run = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan_run  = 1'b1;
                cmd.emit_init = sts.scan_done;
            end
            S_EMIT:
            begin
                cmd.emit_run = 1'b1;
                cmd.commit   = sts.emit_done;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/ldge_dp.sv
// Datapath: entry memory, minimum scan, compaction and result register.
`timescale 1ns / 1ps
`default_nettype none

module ldge_dp
    import ldge_pkg::*;
#(
    parameter int SET_DEPTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_t             cmd,
    output sts_t                  sts,
    input  wire logic             req_opcode,
    input  wire logic [TAG_W-1:0] req_tag,
    input  wire logic [DEG_W-1:0] req_degree,
    input  wire logic             rsp_ready,
    output logic                  rsp_valid,
    output status_t               rsp_status,
    output logic      [TAG_W-1:0] rsp_tag,
    output logic      [DEG_W-1:0] rsp_degree,
    output logic      [CNT_W-1:0] rsp_group,
    output logic      [CNT_W-1:0] rsp_remaining,
    output logic                  rsp_last
);

    localparam int AW = $clog2(SET_DEPTH);
    localparam int CW = $clog2(SET_DEPTH + 1);
    localparam int MW = TAG_W + DEG_W;

    // Control state.
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    rd_idx_reg, rd_idx_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;

    // Working payload.
    logic             op_reg, op_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [DEG_W-1:0] deg_reg, deg_next;
    logic [DEG_W-1:0] lo_reg, lo_next;
    logic [CW-1:0]    len_reg, len_next;
    logic [CW-1:0]    kept_reg, kept_next;
    logic [CW-1:0]    k_reg, k_next;

    status_t          out_status_reg, out_status_next;
    logic [TAG_W-1:0] out_tag_reg, out_tag_next;
    logic [DEG_W-1:0] out_deg_reg, out_deg_next;
    logic [CNT_W-1:0] out_group_reg, out_group_next;
    logic [CNT_W-1:0] out_rem_reg, out_rem_next;
    logic             out_last_reg, out_last_next;

    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [MW-1:0]    ram_wr_data;
    logic             ram_rd_en;
    logic [MW-1:0]    ram_rd_data;

    logic             out_free;
    logic             more;
    logic             match;
    logic [DEG_W-1:0] rd_deg;

    assign out_free = !out_valid_reg || rsp_ready;
    assign more     = rd_idx_reg < count_reg;
    assign rd_deg   = ram_rd_data[DEG_W-1:0];
    assign match    = rd_deg == lo_reg;

    assign sts.out_free   = out_free;
    assign sts.count_zero = count_reg == '0;
    assign sts.scan_done  = !more && !pend_reg;
    assign sts.emit_done  = !more && !pend_reg;

    ldge_ram #(
        .WIDTH(MW),
        .DEPTH(SET_DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(rd_idx_reg[AW-1:0]),
        .rd_data(ram_rd_data)
    );

    always_comb
    begin
        logic consume;
        logic issue;

        consume         = 1'b0;
        issue           = 1'b0;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = pend_reg;
        op_next         = op_reg;
        tag_next        = tag_reg;
        deg_next        = deg_reg;
        lo_next         = lo_reg;
        len_next        = len_reg;
        kept_next       = kept_reg;
        k_next          = k_reg;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_deg_next    = out_deg_reg;
        out_group_next  = out_group_reg;
        out_rem_next    = out_rem_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = count_reg[AW-1:0];
        ram_wr_data     = {tag_reg, deg_reg};
        ram_rd_en       = 1'b0;

        if (cmd.capture)
        begin
            op_next  = req_opcode;
            tag_next = req_tag;
            deg_next = req_degree;
        end

        // Minimum search: one entry read per cycle, compared when its data returns.
        if (cmd.scan_init)
        begin
            rd_idx_next = '0;
            pend_next   = 1'b0;
            lo_next     = '1;
            len_next    = '0;
        end
        else if (cmd.scan_run)
        begin
            issue = more;
            if (pend_reg)
            begin
                if (rd_deg < lo_reg)
                begin
                    lo_next  = rd_deg;
                    len_next = CW'(1);
                end
                else if (match)
                begin
                    len_next = len_reg + 1'b1;
                end
            end
            ram_rd_en   = issue;
            rd_idx_next = rd_idx_reg + CW'(issue);
            pend_next   = issue;
        end

        // Emit matches and compact the survivors toward slot zero.
        if (cmd.emit_init)
        begin
            rd_idx_next = '0;
            pend_next   = 1'b0;
            kept_next   = '0;
            k_next      = '0;
        end
        else if (cmd.emit_run)
        begin
            consume = pend_reg && (!match || out_free);
            issue   = more && (!pend_reg || consume);
            if (consume && !match)
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = kept_reg[AW-1:0];
                ram_wr_data = ram_rd_data;
                kept_next   = kept_reg + 1'b1;
            end
            if (consume && match)
            begin
                out_valid_next  = 1'b1;
                out_status_next = ST_EXTRACTED;
                out_tag_next    = ram_rd_data[MW-1:DEG_W];
                out_deg_next    = lo_reg;
                out_group_next  = CNT_W'(len_reg);
                out_rem_next    = CNT_W'(count_reg - len_reg);
                out_last_next   = (k_reg + 1'b1) == len_reg;
                k_next          = k_reg + 1'b1;
            end
            ram_rd_en   = issue;
            rd_idx_next = rd_idx_reg + CW'(issue);
            pend_next   = issue || (pend_reg && !consume);
        end

        if (cmd.commit)
        begin
            count_next = kept_reg;
        end

        if (cmd.single_run && out_free)
        begin
            out_valid_next = 1'b1;
            out_tag_next   = '0;
            out_deg_next   = '0;
            out_group_next = '0;
            out_last_next  = 1'b1;
            if (op_reg == OP_INSERT)
            begin
                if (count_reg == CW'(SET_DEPTH))
                begin
                    out_status_next = ST_FULL;
                    out_rem_next    = CNT_W'(count_reg);
                end
                else
                begin
                    ram_wr_en       = 1'b1;
                    count_next      = count_reg + 1'b1;
                    out_status_next = ST_INSERTED;
                    out_rem_next    = CNT_W'(count_reg + 1'b1);
                end
            end
            else
            begin
                out_status_next = ST_EMPTY;
                out_rem_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        tag_reg        <= tag_next;
        deg_reg        <= deg_next;
        lo_reg         <= lo_next;
        len_reg        <= len_next;
        kept_reg       <= kept_next;
        k_reg          <= k_next;
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
        out_deg_reg    <= out_deg_next;
        out_group_reg  <= out_group_next;
        out_rem_reg    <= out_rem_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp_valid     = out_valid_reg;
    assign rsp_status    = out_status_reg;
    assign rsp_tag       = out_tag_reg;
    assign rsp_degree    = out_deg_reg;
    assign rsp_group     = out_group_reg;
    assign rsp_remaining = out_rem_reg;
    assign rsp_last      = out_last_reg;

endmodule

`default_nettype wire

### design/lowest_degree_group_extract_top.sv
// Top level of the lowest-degree group extract block.
//
//  Channel | Modport | Direction | Payload
//  --------+---------+-----------+------------------------------------------------------
//  req     | sink    | in        | opcode, entry_tag, entry_degree
//  rsp     | source  | out       | status, out_tag, out_degree, group_count, remaining, last
//
// An insert, or an extract on an empty set, is accepted and then loads the result
// register once it is free. An extract of a non-empty set sweeps the single read port
// of the entry memory twice: once to find the lowest degree and its group size, once
// to emit and compact the rest. A stalled result holds the sweep only when the next
// matching entry needs the register. Reset clears the entry count and all control
// state; the memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module lowest_degree_group_extract_top
    import ldge_pkg::*;
#(
    parameter int SET_DEPTH = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ldge_in_if.sink   req,
    ldge_out_if.source rsp
);

    cmd_t    cmd;
    sts_t    sts;
    status_t rsp_status;

    // The controller decides which phase runs; the datapath does the work.
    ldge_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_opcode(req.opcode),
        .req_ready (req.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ldge_dp #(
        .SET_DEPTH(SET_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_opcode   (req.opcode),
        .req_tag      (req.entry_tag),
        .req_degree   (req.entry_degree),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .rsp_status   (rsp_status),
        .rsp_tag      (rsp.out_tag),
        .rsp_degree   (rsp.out_degree),
        .rsp_group    (rsp.group_count),
        .rsp_remaining(rsp.remaining),
        .rsp_last     (rsp.last)
    );

    assign rsp.status = rsp_status;

endmodule

`default_nettype wire

### design/ldge_checker.sv
// Port-level checker for the lowest-degree group extract block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module ldge_checker
    import ldge_pkg::*;
#(
    parameter int SET_DEPTH = 64
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire logic [1:0]       status,
    input wire logic [TAG_W-1:0] out_tag,
    input wire logic [CNT_W-1:0] group_count,
    input wire logic [CNT_W-1:0] remaining,
    input wire logic             last
);

    // A stalled result stays valid and keeps its status, tag, remaining count and last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_tag)
            && $stable(remaining) && $stable(last))
        else $error("stalled result changed");

    // Only an extract yields more than one result per transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_EXTRACTED |-> last)
        else $error("non-extract result without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY |-> remaining == '0 && group_count == '0
            && out_tag == '0)
        else $error("empty result carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EXTRACTED |-> group_count != '0
            && (32'(group_count) + 32'(remaining)) <= 32'(SET_DEPTH))
        else $error("extract group size out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_INSERTED |-> remaining != '0
            && 32'(remaining) <= 32'(SET_DEPTH))
        else $error("insert count out of range");

endmodule

bind lowest_degree_group_extract_top ldge_checker #(
    .SET_DEPTH(SET_DEPTH)
) u_ldge_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (rsp.status),
    .out_tag    (rsp.out_tag),
    .group_count(rsp.group_count),
    .remaining  (rsp.remaining),
    .last       (rsp.last)
);

`default_nettype wire
